FILE: design/peval_pkg.sv
// ----------------------------------------------------------------------------
// peval_pkg
// Shared types and constants for the fixed-point polynomial evaluator.
// ----------------------------------------------------------------------------
package peval_pkg;

  localparam int MAX_DEGREE = 6;
  localparam int NUM_COEFFS = MAX_DEGREE + 1;

  localparam int X_W     = 16;   // Q4.12
  localparam int Q_W     = 32;   // Q16.16
  localparam int PROD_W  = Q_W + X_W;
  localparam int FRAC_X  = 12;
  localparam int DEG_W   = 3;
  localparam int CFG_IDX_W = $clog2(NUM_COEFFS + 1);

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGREE = CFG_IDX_W'(0),
    REG_COEFF0 = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef logic [NUM_COEFFS-1:0][Q_W-1:0] coeff_vec_t;

  // one sample traveling down the Horner chain
  typedef struct packed {
    logic signed [Q_W-1:0] acc;
    logic signed [X_W-1:0] x;
    logic                  sat;
  } item_t;

endpackage

FILE: design/peval_if.sv
// ----------------------------------------------------------------------------
// peval_x_if / peval_result_if
// Valid/ready channels for samples in and polynomial values out.
// ----------------------------------------------------------------------------
interface peval_x_if import peval_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

interface peval_result_if import peval_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] poly_value;
  logic                  saturated;

  modport source (output valid, output poly_value, output saturated, input ready);
  modport sink (input valid, input poly_value, input saturated, output ready);
endinterface

FILE: design/peval_cfg.sv
// ----------------------------------------------------------------------------
// peval_cfg
// Degree and coefficient registers with the write port decode.
// ----------------------------------------------------------------------------
module peval_cfg import peval_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_data,
  output logic [DEG_W-1:0]     degree,
  output coeff_vec_t           coeffs
);

  logic [DEG_W-1:0] poly_degree;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_degree <= '0;
      coeffs      <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_DEGREE) begin
        poly_degree <= cfg_data[DEG_W-1:0];
      end
      for (int i = 0; i < NUM_COEFFS; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_COEFF0) + CFG_IDX_W'(i)) begin
          coeffs[i] <= cfg_data;
        end
      end
    end
  end

  // degrees above the supported maximum clamp to it
  assign degree = (poly_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : poly_degree;

endmodule

FILE: design/peval_step.sv
// ----------------------------------------------------------------------------
// peval_step
// One Horner step in two stages: multiply by x, then round, clamp, add the
// coefficient and clamp again. An inactive step passes the sample through.
// ----------------------------------------------------------------------------
module peval_step import peval_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  active,
  input  logic signed [Q_W-1:0] coeff,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  item_t                 in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output item_t                 out_item
);

  // multiply stage
  logic                     a_valid;
  logic signed [PROD_W-1:0] a_prod;
  item_t                    a_item;
  logic                     a_act;
  logic                     a_ready;

  logic                     b_ready;
  logic signed [PROD_W-1:0] prod_full;

  assign prod_full = in_item.acc * in_item.x;
  assign b_ready   = !out_valid || out_ready;
  assign a_ready   = !a_valid || b_ready;
  assign in_ready  = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_prod <= prod_full;
      a_item <= in_item;
      a_act  <= active;
    end
  end

  // round / add stage
  logic signed [PROD_W-1:0] rounded;
  logic signed [Q_W-1:0]    prod_q;
  logic                     prod_sat;
  logic signed [Q_W:0]      sum_full;
  logic signed [Q_W-1:0]    sum_q;
  logic                     sum_sat;
  item_t                    item_next;

  always_comb begin
    // add half an lsb, then arithmetic shift floors
    rounded = (a_prod + PROD_W'(signed'(2048))) >>> FRAC_X;
    if (rounded > PROD_W'(Q_MAX)) begin
      prod_q   = Q_MAX;
      prod_sat = 1'b1;
    end else if (rounded < PROD_W'(Q_MIN)) begin
      prod_q   = Q_MIN;
      prod_sat = 1'b1;
    end else begin
      prod_q   = rounded[Q_W-1:0];
      prod_sat = 1'b0;
    end

    sum_full = (Q_W+1)'(prod_q) + (Q_W+1)'(coeff);
    if (sum_full[Q_W] != sum_full[Q_W-1]) begin
      sum_q   = sum_full[Q_W] ? Q_MIN : Q_MAX;
      sum_sat = 1'b1;
    end else begin
      sum_q   = sum_full[Q_W-1:0];
      sum_sat = 1'b0;
    end

    item_next = a_item;
    if (a_act) begin
      item_next.acc = sum_q;
      item_next.sat = a_item.sat | prod_sat | sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: design/polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Evaluates p(x) = sum coeff_i * x^i by Horner's rule, in fixed point.
// ----------------------------------------------------------------------------
// One sample enters per cycle while no backpressure holds the chain, and its
// result passes through 1 + 2 * MAX_DEGREE register stages: a load stage
// picks the leading coefficient, then each of the six Horner steps registers
// the product of its 32x16 multiplier and then the result of rounding,
// clamping and adding the next coefficient. Steps above the configured degree
// pass the sample unchanged, so latency does not depend on the degree. Valid
// bits travel with every stage and bubbles are squeezed out under
// backpressure. Write the degree and coefficients only while no sample is in
// flight.
module polynomial_evaluator import peval_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_data,
  peval_x_if.sink              x_in,
  peval_result_if.source       result
);

  logic [DEG_W-1:0] degree;
  coeff_vec_t       coeffs;

  peval_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .degree    (degree),
    .coeffs    (coeffs)
  );

  // link k feeds step k; link MAX_DEGREE is the output register
  // link_ready[k+1] is step k's input ready, the last entry is the sink ready
  logic  link_valid [MAX_DEGREE+1];
  logic  link_ready [MAX_DEGREE+2];
  item_t link_item  [MAX_DEGREE+1];
  logic  link_ready_in0;

  assign link_ready[0] = !link_valid[0] || link_ready_in0;
  assign x_in.ready = link_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid[0] <= 1'b0;
    end else if (link_ready[0]) begin
      link_valid[0] <= x_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (link_ready[0] && x_in.valid) begin
      link_item[0].acc <= coeffs[degree];
      link_item[0].x   <= x_in.x_value;
      link_item[0].sat <= 1'b0;
    end
  end

  for (genvar s = 0; s < MAX_DEGREE; s++) begin : g_step
    logic active;
    // step s applies coefficient MAX_DEGREE-1-s when that is below the degree
    assign active = (4'(degree) + 4'(s)) >= 4'(MAX_DEGREE);

    peval_step u_step (
      .clk       (clk),
      .rst       (rst),
      .active    (active),
      .coeff     (coeffs[MAX_DEGREE-1-s]),
      .in_valid  (link_valid[s]),
      .in_ready  (link_ready[s+1]),
      .in_item   (link_item[s]),
      .out_valid (link_valid[s+1]),
      .out_ready (link_ready[s+2]),
      .out_item  (link_item[s+1])
    );
  end

  assign link_ready_in0 = link_ready[1];
  assign link_ready[MAX_DEGREE+1] = result.ready;

  assign result.valid      = link_valid[MAX_DEGREE];
  assign result.poly_value = link_item[MAX_DEGREE].acc;
  assign result.saturated  = link_item[MAX_DEGREE].sat;

endmodule

FILE: design/peval_checker.sv
// ----------------------------------------------------------------------------
// peval_checker
// Port-level checks on the polynomial evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module peval_checker import peval_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_wr_en,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [Q_W-1:0]       cfg_data,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [Q_W-1:0]       poly_value,
  input logic                 saturated
);

  // shadow of whether the degree in use is zero
  logic deg_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_zero <= 1'b1;
    end else if (cfg_wr_en && cfg_index == REG_DEGREE) begin
      deg_zero <= (cfg_data[DEG_W-1:0] == '0);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(poly_value) && $stable(saturated))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_free_flow: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side is free");

  a_deg_zero_nosat: assert property (@(posedge clk) disable iff (rst)
    out_valid && deg_zero |-> !saturated)
    else $error("saturation reported with degree zero");

endmodule

bind polynomial_evaluator peval_checker u_peval_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_wr_en  (cfg_wr_en),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data),
  .in_ready   (x_in.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .poly_value (result.poly_value),
  .saturated  (result.saturated)
);
